>>> design/batched_ring_queue_macros.svh
// assertion macros for the batched ring queue
`ifndef BATCHED_RING_QUEUE_MACROS_SVH
`define BATCHED_RING_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk_i, off while in reset
`define BRQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, clocked on clk_i, off while in reset
`define BRQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BRQ_ASSERT_IMP(lbl, ante, cons, msg)
`define BRQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/brq_pkg.sv
// shared types and constants of the batched ring queue
package brq_pkg;

  localparam int unsigned BRQ_QUEUE_DEPTH = 1024;
  localparam int unsigned BRQ_DATA_WIDTH  = 64;
  localparam int unsigned BRQ_IO_W        = 64;  // port width of data fields
  localparam int unsigned BRQ_CFG_W       = 10;  // widest config register
  localparam int unsigned BRQ_CFG_IDX_W   = 3;

  localparam logic [BRQ_CFG_W-1:0] BRQ_PROD_BATCH_RST = 10'd64;
  localparam logic [BRQ_CFG_W-1:0] BRQ_CONS_BATCH_RST = 10'd64;
  localparam logic [BRQ_CFG_W-1:0] BRQ_INCREMENT_RST  = 10'd16;

  typedef enum logic [BRQ_CFG_IDX_W-1:0] {
    CFG_PROD_BATCH_EN   = 3'd0,
    CFG_CONS_BATCH_EN   = 3'd1,
    CFG_BACKTRACK_EN    = 3'd2,
    CFG_ADAPTIVE_EN     = 3'd3,
    CFG_PROD_BATCH_SIZE = 3'd4,
    CFG_CONS_BATCH_SIZE = 3'd5,
    CFG_BATCH_INCREMENT = 3'd6
  } brq_cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ZERO  = 2'd3
  } brq_status_e;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } brq_op_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_TAKE
  } brq_state_e;

  typedef enum logic [2:0] {
    K_ZERO,
    K_ENQ_PLAIN,
    K_ENQ_RUN,
    K_ENQ_CLAIM,
    K_DEQ_PLAIN,
    K_DEQ_RUN,
    K_DEQ_CLAIM
  } brq_kind_e;

  typedef struct packed {
    logic                 prod_batch_en;
    logic                 cons_batch_en;
    logic                 backtrack_en;
    logic                 adaptive_en;
    logic [BRQ_CFG_W-1:0] prod_probe_len;
    logic [BRQ_CFG_W-1:0] cons_probe_len;
    logic [BRQ_CFG_W-1:0] batch_increment;
  } brq_cfg_t;

  typedef struct packed {
    brq_status_e         status;
    logic [BRQ_IO_W-1:0] data;
  } brq_result_t;

endpackage

>>> design/brq_ram.sv
// slot store: one write port, one read port, registered read data
module brq_ram
  import brq_pkg::*;
#(
  parameter int unsigned DEPTH = BRQ_QUEUE_DEPTH,
  parameter int unsigned WIDTH = BRQ_DATA_WIDTH,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/brq_seq.sv
// queue sequencer: index state, probe and backtrack control, slot read-modify-write
module brq_seq
  import brq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = BRQ_QUEUE_DEPTH,
  parameter int unsigned DATA_WIDTH  = BRQ_DATA_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  brq_cfg_t            cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [BRQ_IO_W-1:0] data_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output brq_result_t         res_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned SW = ((IW > BRQ_CFG_W) ? IW : BRQ_CFG_W) + 1;

  // positions at or past the end fall back to slot 0
  function automatic logic [IW-1:0] clip(input logic [SW-1:0] pos);
    return (pos >= SW'(QUEUE_DEPTH)) ? '0 : pos[IW-1:0];
  endfunction

  brq_state_e state_q, state_d;
  brq_kind_e  kind_q, kind_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [IW-1:0] wi_q, wi_d, ri_q, ri_d, wbl_q, wbl_d, rbl_q, rbl_d;
  logic [IW-1:0] probe_q, probe_d, clr_q, clr_d;
  logic [BRQ_CFG_W-1:0] learned_q, learned_d, dist_q, dist_d;

  logic                  ram_we, ram_re;
  logic [IW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [DATA_WIDTH-1:0] v_in;
  logic [SW-1:0]         cons_sum;
  logic [BRQ_CFG_W:0]    grown;
  logic [BRQ_CFG_W-1:0]  learned_new, dist_half;
  logic [IW-1:0]         wi_inc, ri_inc;
  logic                  slot_full;

  brq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      kind_q    <= K_ZERO;
      wi_q      <= '0;
      ri_q      <= '0;
      wbl_q     <= '0;
      rbl_q     <= '0;
      clr_q     <= '0;
      learned_q <= BRQ_CONS_BATCH_RST;
    end else begin
      state_q   <= state_d;
      kind_q    <= kind_d;
      wi_q      <= wi_d;
      ri_q      <= ri_d;
      wbl_q     <= wbl_d;
      rbl_q     <= rbl_d;
      clr_q     <= clr_d;
      learned_q <= learned_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    probe_q <= probe_d;
    dist_q  <= dist_d;
  end

  assign v_in      = data_i[DATA_WIDTH-1:0];
  assign cons_sum  = SW'(ri_q) + SW'(cfg_i.cons_probe_len);
  assign grown     = {1'b0, learned_q} + {1'b0, cfg_i.batch_increment};
  assign dist_half = dist_q >> 1;
  assign wi_inc    = clip(SW'(wi_q) + SW'(1));
  assign ri_inc    = clip(SW'(ri_q) + SW'(1));
  assign slot_full = (ram_rdata != '0);

  // adaptive size grows when the probe runs past the end of the ring
  always_comb begin
    learned_new = learned_q;
    if ((cons_sum >= SW'(QUEUE_DEPTH)) && cfg_i.adaptive_en &&
        (learned_q < cfg_i.cons_probe_len)) begin
      learned_new = (grown > {1'b0, cfg_i.cons_probe_len}) ?
                    cfg_i.cons_probe_len : grown[BRQ_CFG_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    data_d      = data_q;
    wi_d        = wi_q;
    ri_d        = ri_q;
    wbl_d       = wbl_q;
    rbl_d       = rbl_q;
    probe_d     = probe_q;
    clr_d       = clr_q;
    learned_d   = learned_q;
    dist_d      = dist_q;
    ram_we      = 1'b0;
    ram_waddr   = wi_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = ri_q;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    res_o       = '{status: ST_OK, data: '0};

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + IW'(1);
        if (clr_q == IW'(QUEUE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          data_d  = v_in;
          state_d = S_CHECK;
          if (op_i == OP_ENQ) begin
            if (v_in == '0) begin
              kind_d = K_ZERO;
            end else if (cfg_i.prod_batch_en) begin
              if (wi_q == wbl_q) begin
                kind_d    = K_ENQ_CLAIM;
                probe_d   = clip(SW'(wi_q) + SW'(cfg_i.prod_probe_len));
                ram_re    = 1'b1;
                ram_raddr = probe_d;
              end else begin
                kind_d = K_ENQ_RUN;
              end
            end else begin
              kind_d    = K_ENQ_PLAIN;
              ram_re    = 1'b1;
              ram_raddr = wi_q;
            end
          end else begin
            if (!cfg_i.cons_batch_en) begin
              kind_d    = K_DEQ_PLAIN;
              ram_re    = 1'b1;
              ram_raddr = ri_q;
            end else if (ri_q != rbl_q) begin
              kind_d    = K_DEQ_RUN;
              ram_re    = 1'b1;
              ram_raddr = ri_q;
            end else begin
              kind_d    = K_DEQ_CLAIM;
              probe_d   = clip(cons_sum);
              learned_d = learned_new;
              dist_d    = cfg_i.adaptive_en ? learned_new : cfg_i.cons_probe_len;
              ram_re    = 1'b1;
              ram_raddr = probe_d;
            end
          end
        end
      end

      S_CHECK: begin
        case (kind_q)
          K_ZERO: begin
            res_valid_o = 1'b1;
            res_o       = '{status: ST_ZERO, data: '0};
            if (res_ready_i) begin
              state_d = S_IDLE;
            end
          end
          K_ENQ_PLAIN, K_ENQ_RUN, K_ENQ_CLAIM: begin
            res_valid_o = 1'b1;
            if ((kind_q != K_ENQ_RUN) && slot_full) begin
              res_o = '{status: ST_FULL, data: '0};
              if (res_ready_i) begin
                state_d = S_IDLE;
              end
            end else begin
              res_o = '{status: ST_OK, data: '0};
              if (res_ready_i) begin
                ram_we    = 1'b1;
                ram_waddr = wi_q;
                ram_wdata = data_q;
                wi_d      = wi_inc;
                if (kind_q == K_ENQ_CLAIM) begin
                  wbl_d = probe_q;
                end
                state_d = S_IDLE;
              end
            end
          end
          K_DEQ_PLAIN, K_DEQ_RUN: begin
            res_valid_o = 1'b1;
            if ((kind_q == K_DEQ_PLAIN) && !slot_full) begin
              res_o = '{status: ST_EMPTY, data: '0};
              if (res_ready_i) begin
                state_d = S_IDLE;
              end
            end else begin
              res_o = '{status: ST_OK, data: BRQ_IO_W'(ram_rdata)};
              if (res_ready_i) begin
                ram_we    = 1'b1;
                ram_waddr = ri_q;
                ri_d      = ri_inc;
                state_d   = S_IDLE;
              end
            end
          end
          K_DEQ_CLAIM: begin
            if (slot_full) begin
              // run claimed, now fetch the read slot itself
              if (cfg_i.backtrack_en && cfg_i.adaptive_en) begin
                learned_d = dist_q;
              end
              rbl_d     = (probe_q == ri_q) ? ri_inc : probe_q;
              ram_re    = 1'b1;
              ram_raddr = ri_q;
              state_d   = S_TAKE;
            end else if (cfg_i.backtrack_en && (dist_q != '0)) begin
              // halve the distance and probe again
              dist_d    = dist_half;
              probe_d   = clip(SW'(ri_q) + SW'(dist_half));
              ram_re    = 1'b1;
              ram_raddr = probe_d;
            end else begin
              res_valid_o = 1'b1;
              res_o       = '{status: ST_EMPTY, data: '0};
              if (res_ready_i) begin
                state_d = S_IDLE;
              end
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_TAKE: begin
        res_valid_o = 1'b1;
        res_o       = '{status: ST_OK, data: BRQ_IO_W'(ram_rdata)};
        if (res_ready_i) begin
          ram_we    = 1'b1;
          ram_waddr = ri_q;
          ri_d      = ri_inc;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/batched_ring_queue.sv
// top level of the batched ring queue: config registers, result register, checks
// Single-producer single-consumer ring queue over a slot memory of QUEUE_DEPTH
// entries of DATA_WIDTH bits, where a nonzero slot holds an entry and a zero
// slot is free. Each input beat is one enqueue or dequeue and yields exactly
// one result beat (status, and the value on a successful dequeue). After
// reset the slot memory is swept to zero, one slot a cycle, so the input
// side stalls until the sweep ends; config writes are taken at any time.
// For an item, the slot (or probe) read is issued in the accept cycle and
// the check happens in the next, with any write-back once the result is taken,
// all through the single read and single write port of the slot memory. A
// consumer batch claim adds a fetch of the read slot in S_TAKE, plus one
// halving probe per empty probed slot when backtracking.
// Results sit in an output register, so the next beat is accepted while a
// result waits; a full output register holds the sequencer at its last step.
`include "batched_ring_queue_macros.svh"

module batched_ring_queue
  import brq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = BRQ_QUEUE_DEPTH,
  parameter int unsigned DATA_WIDTH  = BRQ_DATA_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config write port
  input  logic                     cfg_we_i,
  input  logic [BRQ_CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BRQ_CFG_W-1:0]     cfg_data_i,
  // input beats
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     operation_i,
  input  logic [BRQ_IO_W-1:0]      data_in_i,
  // result beats
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [BRQ_IO_W-1:0]      data_out_o
);

  brq_cfg_t    cfg_q, cfg_d;
  brq_result_t res;
  logic        res_valid, res_ready;

  logic                out_valid_q, out_valid_d;
  logic [1:0]          status_q;
  logic [BRQ_IO_W-1:0] data_out_q;

  // config registers, index per register list
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PROD_BATCH_EN:   cfg_d.prod_batch_en   = cfg_data_i[0];
        CFG_CONS_BATCH_EN:   cfg_d.cons_batch_en   = cfg_data_i[0];
        CFG_BACKTRACK_EN:    cfg_d.backtrack_en    = cfg_data_i[0];
        CFG_ADAPTIVE_EN:     cfg_d.adaptive_en     = cfg_data_i[0];
        CFG_PROD_BATCH_SIZE: cfg_d.prod_probe_len  = cfg_data_i;
        CFG_CONS_BATCH_SIZE: cfg_d.cons_probe_len  = cfg_data_i;
        CFG_BATCH_INCREMENT: cfg_d.batch_increment = cfg_data_i;
        default:             cfg_d = cfg_q;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{prod_batch_en:   1'b0,
                 cons_batch_en:   1'b0,
                 backtrack_en:    1'b0,
                 adaptive_en:     1'b0,
                 prod_probe_len:  BRQ_PROD_BATCH_RST,
                 cons_probe_len:  BRQ_CONS_BATCH_RST,
                 batch_increment: BRQ_INCREMENT_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // sequencer with the slot memory
  brq_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (operation_i),
    .data_i      (data_in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register: loads when empty or when its beat leaves this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      status_q   <= res.status;
      data_out_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_out_o  = data_out_q;

  // a result held back by the output register must not change
  `BRQ_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "sequencer result changed while blocked")

  // only a successful dequeue carries a value
  `BRQ_ASSERT_IMP(a_fail_zero, out_valid_o && (status_o != ST_OK), data_out_o == '0, "failed beat carries data")

  // one item at a time: an accepted beat blocks the next cycle
  `BRQ_ASSERT_NXT(a_one_item, in_valid_i && !in_stall_o, in_stall_o, "input taken while an item is in work")

endmodule

>>> dv/tb.sv
// self-checking testbench of batched_ring_queue: directed beats, then random phases against a predictor
module tb;
  import brq_pkg::*;

  localparam int unsigned DEPTH     = BRQ_QUEUE_DEPTH;
  localparam logic [63:0] DATA_MASK = {64{1'b1}} >> (64 - BRQ_DATA_WIDTH);
  // cycles without any beat before giving up; covers the clearing sweep
  // after reset, the longest sender gap, the longest result stall and a claim
  localparam int WATCHDOG_LIMIT = 4000;
  // settle time for a claim with backtracking over 1023 slots
  localparam int SETTLE_CYCLES  = 16;
  localparam int MAX_REPORTS    = 100;

  typedef enum logic {
    ROW_CFG,
    ROW_BEAT
  } row_kind_e;

  // one row of the directed part: a register write or an input beat,
  // with an optional hand-written expected result
  typedef struct packed {
    row_kind_e            kind;
    brq_cfg_idx_e         reg_sel;
    logic [BRQ_CFG_W-1:0] reg_val;
    brq_op_e              op;
    logic [63:0]          word;
    logic                 typed;
    brq_status_e          want_status;
    logic [63:0]          want_data;
  } dir_row_t;

  localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TOP   = 64'h8000_0000_0000_0000;
  localparam int          N_DIR = 40;

  localparam dir_row_t DIRECTED [N_DIR] = '{
    // empty queue after reset, then zero value, then the data extremes
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_DEQ, 64'd0,   1'b1, ST_EMPTY, 64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_ENQ, 64'd0,   1'b1, ST_ZERO,  64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_ENQ, ONES,    1'b1, ST_OK,    64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_ENQ, 64'd1,   1'b1, ST_OK,    64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_ENQ, TOP,     1'b1, ST_OK,    64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_DEQ, 64'd0,   1'b1, ST_OK,    ONES},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_DEQ, 64'd0,   1'b1, ST_OK,    64'd1},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_DEQ, ONES,    1'b1, ST_OK,    TOP},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_DEQ, 64'd0,   1'b1, ST_EMPTY, 64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_ENQ, 64'h5555_5555_5555_5555,
      1'b0, ST_OK, 64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_ENQ, 64'hAAAA_AAAA_AAAA_AAAA,
      1'b0, ST_OK, 64'd0},
    // producer batching with a probe distance of zero
    '{ROW_CFG,  CFG_PROD_BATCH_SIZE, 10'd0,    OP_ENQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_CFG,  CFG_PROD_BATCH_EN,   10'd1,    OP_ENQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_ENQ, 64'h1234, 1'b0, ST_OK,   64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_ENQ, 64'd0,   1'b1, ST_ZERO,  64'd0},
    // consumer batching with distance zero, claims the read slot itself
    '{ROW_CFG,  CFG_CONS_BATCH_SIZE, 10'd0,    OP_ENQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_CFG,  CFG_CONS_BATCH_EN,   10'd1,    OP_ENQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_DEQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_DEQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_DEQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_DEQ, 64'd0,   1'b0, ST_OK,    64'd0},
    // widest distances: probe past the end, backtracking, adaptive growth
    '{ROW_CFG,  CFG_CONS_BATCH_SIZE, 10'd1023, OP_ENQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_CFG,  CFG_BACKTRACK_EN,    10'd1,    OP_ENQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_CFG,  CFG_ADAPTIVE_EN,     10'd1,    OP_ENQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_CFG,  CFG_BATCH_INCREMENT, 10'd1023, OP_ENQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_CFG,  CFG_PROD_BATCH_SIZE, 10'd1023, OP_ENQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_ENQ, 64'h77,  1'b0, ST_OK,    64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_ENQ, 64'h88,  1'b0, ST_OK,    64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_DEQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_DEQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_DEQ, 64'd0,   1'b0, ST_OK,    64'd0},
    // everything back to reset values, stale limits stay in the block
    '{ROW_CFG,  CFG_PROD_BATCH_EN,   10'd0,    OP_ENQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_CFG,  CFG_CONS_BATCH_EN,   10'd0,    OP_ENQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_CFG,  CFG_BACKTRACK_EN,    10'd0,    OP_ENQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_CFG,  CFG_ADAPTIVE_EN,     10'd0,    OP_ENQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_CFG,  CFG_PROD_BATCH_SIZE, 10'd64,   OP_ENQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_CFG,  CFG_CONS_BATCH_SIZE, 10'd64,   OP_ENQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_CFG,  CFG_BATCH_INCREMENT, 10'd16,   OP_ENQ, 64'd0,   1'b0, ST_OK,    64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_ENQ, 64'h99,  1'b0, ST_OK,    64'd0},
    '{ROW_BEAT, CFG_PROD_BATCH_EN,   10'd0,    OP_DEQ, 64'd0,   1'b0, ST_OK,    64'd0}
  };

  localparam brq_result_t NO_WANT = '{status: ST_OK, data: 64'd0};

  // block ports
  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [BRQ_CFG_IDX_W-1:0] cfg_index_i;
  logic [BRQ_CFG_W-1:0]     cfg_data_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     operation_i;
  logic [BRQ_IO_W-1:0]      data_in_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [1:0]               status_o;
  logic [BRQ_IO_W-1:0]      data_out_o;

  batched_ring_queue uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_out_o  (data_out_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor: own copy of the slot store, the pointers and the registers
  // ---------------------------------------------------------------------
  logic [63:0] ring_mirror [DEPTH];
  int unsigned wr_pos, rd_pos;          // next slot to write and to read
  int unsigned wr_run_end, rd_run_end;  // end of the claimed producer / consumer run
  int unsigned learned_run;             // adaptive consumer distance
  brq_cfg_t    cfg_mirror;

  // results still owed by the block, oldest first
  brq_result_t due_results [$];

  // hand-written expectation that travels with the beat on the input side
  logic        beat_typed;
  brq_result_t beat_want;

  // idling controls, changed per phase
  logic send_gaps_on;
  logic stall_gaps_on;

  int err_count;
  int idle_cycles;

  // positions at or past the end fall back to slot 0, no modulo
  function automatic int unsigned wrap_pos(int unsigned pos);
    return (pos >= DEPTH) ? 0 : pos;
  endfunction

  function automatic void reset_mirror();
    foreach (ring_mirror[i]) ring_mirror[i] = '0;
    wr_pos      = 0;
    rd_pos      = 0;
    wr_run_end  = 0;
    rd_run_end  = 0;
    learned_run = BRQ_CONS_BATCH_RST;
    cfg_mirror  = '{prod_batch_en: 1'b0, cons_batch_en: 1'b0, backtrack_en: 1'b0,
                    adaptive_en: 1'b0, prod_probe_len: BRQ_PROD_BATCH_RST,
                    cons_probe_len: BRQ_CONS_BATCH_RST,
                    batch_increment: BRQ_INCREMENT_RST};
  endfunction

  // consumer reached the end of its run: probe ahead for a filled slot
  function automatic logic claim_consumer_run();
    int unsigned probe;
    int unsigned span;
    int unsigned grown;
    probe = rd_pos + cfg_mirror.cons_probe_len;
    if (probe >= DEPTH) begin
      // probe past the end counts as a wrap: grow the adaptive distance
      probe = 0;
      if (cfg_mirror.adaptive_en && learned_run < cfg_mirror.cons_probe_len) begin
        grown = learned_run + cfg_mirror.batch_increment;
        learned_run = (grown > cfg_mirror.cons_probe_len) ? cfg_mirror.cons_probe_len
                                                          : grown;
      end
    end
    if (cfg_mirror.backtrack_en) begin
      span = cfg_mirror.adaptive_en ? learned_run : cfg_mirror.cons_probe_len;
      // halve while the probed slot is empty; distance zero is the floor
      while (ring_mirror[probe] == '0) begin
        if (span == 0) return 1'b0;
        span  = span >> 1;
        probe = wrap_pos(rd_pos + span);
      end
      if (cfg_mirror.adaptive_en) learned_run = span & 32'h3FF;
    end else if (ring_mirror[probe] == '0) begin
      return 1'b0;
    end
    // probe landed on the read slot: claim exactly that one entry
    if (probe == rd_pos) probe = wrap_pos(probe + 1);
    rd_run_end = probe;
    return 1'b1;
  endfunction

  // result of one accepted beat, updating the mirror state
  function automatic brq_result_t predict_queue_op(brq_op_e op, logic [63:0] word);
    brq_result_t res;
    logic [63:0] val;
    int unsigned probe;
    logic        ok;
    res.status = ST_OK;
    res.data   = '0;
    if (op == OP_ENQ) begin
      val = word & DATA_MASK;
      if (val == '0) begin
        res.status = ST_ZERO;
      end else begin
        ok = (ring_mirror[wr_pos] == '0);
        if (cfg_mirror.prod_batch_en) begin
          // inside a claimed run the slot is written without a check
          ok = 1'b1;
          if (wr_pos == wr_run_end) begin
            probe = wrap_pos(wr_pos + cfg_mirror.prod_probe_len);
            if (ring_mirror[probe] != '0) ok = 1'b0;
            else wr_run_end = probe;
          end
        end
        if (ok) begin
          ring_mirror[wr_pos] = val;
          wr_pos = wrap_pos(wr_pos + 1);
        end else begin
          res.status = ST_FULL;
        end
      end
    end else begin
      if (!cfg_mirror.cons_batch_en) ok = (ring_mirror[rd_pos] != '0);
      else if (rd_pos != rd_run_end) ok = 1'b1;  // stale runs may return zero
      else ok = claim_consumer_run();
      if (ok) begin
        res.data = ring_mirror[rd_pos];
        ring_mirror[rd_pos] = '0;
        rd_pos = wrap_pos(rd_pos + 1);
      end else begin
        res.status = ST_EMPTY;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // monitor: sample at the rising edge, predict on input beats, check
  // result beats, and watch for a stuck block
  // ---------------------------------------------------------------------
  function automatic void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t tb: %s mismatch, expected %h, actual %h", $time, what, want, got);
  endfunction

  always @(posedge clk_i) begin
    brq_result_t want;
    brq_result_t guess;
    if (rst_ni) begin
      // result beat first: it can never belong to a beat taken on this edge
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t tb: result beat with none due, expected nothing, actual %0d/%h",
                     $time, status_o, data_out_o);
        end else begin
          want = due_results.pop_front();
          if (status_o != want.status) flag_mismatch("status", 64'(want.status), 64'(status_o));
          if (data_out_o != want.data) flag_mismatch("data_out", want.data, data_out_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        guess = predict_queue_op(brq_op_e'(operation_i), data_in_i);
        due_results.push_back(beat_typed ? beat_want : guess);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t tb: no beat for %0d cycles, %0d results due", $time, idle_cycles,
                 due_results.size());
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // idling: mostly short gaps, a few long ones
  // ---------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side stall, stall runs always separated by open cycles
  int unsigned stall_left;
  always @(negedge clk_i) begin
    if (!stall_gaps_on) begin
      out_stall_i = 1'b0;
      stall_left  = 0;
    end else if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
      stall_left  = pick_gap();
    end
  end

  // ---------------------------------------------------------------------
  // sender side, everything driven at the falling edge
  // ---------------------------------------------------------------------
  function automatic logic [63:0] rand_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return '1;
    if (r < 12) return 64'd1 << $urandom_range(0, 63);
    if (r < 18) return 64'($urandom_range(1, 255));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [BRQ_CFG_W-1:0] rand_size();
    case ($urandom_range(0, 19))
      0:       return 10'd0;
      1:       return 10'd1023;
      2:       return 10'd512;
      3:       return 10'd1;
      4:       return BRQ_CFG_W'($urandom_range(65, 1023));
      default: return BRQ_CFG_W'($urandom_range(1, 64));
    endcase
  endfunction

  // present one beat and hold it until taken; returns at the next falling edge
  task automatic send_beat(brq_op_e op, logic [63:0] word, logic typed, brq_result_t want);
    int unsigned gap;
    gap = send_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    operation_i = op;
    data_in_i   = word;
    beat_typed  = typed;
    beat_want   = want;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // drop valid and wait until every result is back and any claim has settled
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(brq_cfg_idx_e sel, logic [BRQ_CFG_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = sel;
    cfg_data_i  = val;
    case (sel)
      CFG_PROD_BATCH_EN:   cfg_mirror.prod_batch_en   = val[0];
      CFG_CONS_BATCH_EN:   cfg_mirror.cons_batch_en   = val[0];
      CFG_BACKTRACK_EN:    cfg_mirror.backtrack_en    = val[0];
      CFG_ADAPTIVE_EN:     cfg_mirror.adaptive_en     = val[0];
      CFG_PROD_BATCH_SIZE: cfg_mirror.prod_probe_len  = val;
      CFG_CONS_BATCH_SIZE: cfg_mirror.cons_probe_len  = val;
      CFG_BATCH_INCREMENT: cfg_mirror.batch_increment = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_config(logic pe, logic ce, logic be, logic ae,
                            logic [BRQ_CFG_W-1:0] ps, logic [BRQ_CFG_W-1:0] cs,
                            logic [BRQ_CFG_W-1:0] inc);
    wait_idle();
    write_reg(CFG_PROD_BATCH_EN, BRQ_CFG_W'(pe));
    write_reg(CFG_CONS_BATCH_EN, BRQ_CFG_W'(ce));
    write_reg(CFG_BACKTRACK_EN, BRQ_CFG_W'(be));
    write_reg(CFG_ADAPTIVE_EN, BRQ_CFG_W'(ae));
    write_reg(CFG_PROD_BATCH_SIZE, ps);
    write_reg(CFG_CONS_BATCH_SIZE, cs);
    write_reg(CFG_BATCH_INCREMENT, inc);
  endtask

  // random beats, enq_pct percent of them enqueues
  task automatic run_burst(int n, int unsigned enq_pct, logic send_gaps, logic stall_gaps);
    brq_op_e op;
    send_gaps_on  = send_gaps;
    stall_gaps_on = stall_gaps;
    for (int i = 0; i < n; i++) begin
      // now and then the sender holds off until the block has drained
      if ($urandom_range(0, 199) == 0) wait_idle();
      op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
      send_beat(op, rand_word(), 1'b0, NO_WANT);
    end
  endtask

  // ---------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------
  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_PROD_BATCH_EN;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    operation_i   = OP_ENQ;
    data_in_i     = '0;
    out_stall_i   = 1'b0;
    beat_typed    = 1'b0;
    beat_want     = NO_WANT;
    send_gaps_on  = 1'b0;
    stall_gaps_on = 1'b0;
    stall_left    = 0;
    err_count     = 0;
    idle_cycles   = 0;
    reset_mirror();
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part; the first beat waits out the clearing sweep
    send_gaps_on  = 1'b1;
    stall_gaps_on = 1'b1;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(DIRECTED[i].reg_sel, DIRECTED[i].reg_val);
      end else begin
        send_beat(DIRECTED[i].op, DIRECTED[i].word, DIRECTED[i].typed,
                  '{status: DIRECTED[i].want_status, data: DIRECTED[i].want_data});
      end
    end

    // plain queue, then producer probing at distance one
    set_config(1'b0, 1'b0, 1'b0, 1'b0, 10'd64, 10'd64, 10'd16);
    run_burst(50, 55, 1'b1, 1'b1);
    set_config(1'b1, 1'b0, 1'b0, 1'b0, 10'd1, 10'd64, 10'd16);
    run_burst(50, 55, 1'b1, 1'b0);
    // both sides probing the current slot, back to back beats
    set_config(1'b1, 1'b1, 1'b0, 1'b0, 10'd0, 10'd0, 10'd16);
    run_burst(50, 50, 1'b0, 1'b0);
    // backtracking from a wide distance
    set_config(1'b1, 1'b1, 1'b1, 1'b0, 10'd64, 10'd512, 10'd16);
    run_burst(60, 60, 1'b0, 1'b1);
    // widest distances, adaptive growth by one
    set_config(1'b1, 1'b1, 1'b1, 1'b1, 10'd1023, 10'd1023, 10'd1);
    run_burst(60, 55, 1'b1, 1'b1);
    // small distances, increment far above the ceiling
    set_config(1'b1, 1'b1, 1'b1, 1'b1, 10'd3, 10'd5, 10'd512);
    run_burst(60, 50, 1'b1, 1'b1);
    // adaptive without backtracking only grows the learned distance
    set_config(1'b0, 1'b1, 1'b0, 1'b1, 10'd7, 10'd700, 10'd100);
    run_burst(50, 55, 1'b1, 1'b1);
    // consumer batching off and on again reuses the old run limit
    set_config(1'b0, 1'b0, 1'b1, 1'b1, 10'd7, 10'd700, 10'd100);
    run_burst(40, 50, 1'b1, 1'b1);
    set_config(1'b0, 1'b1, 1'b1, 1'b0, 10'd7, 10'd700, 10'd100);
    run_burst(40, 40, 1'b1, 1'b1);

    // short fill through the plain queue, then drain it through the
    // batched consumer
    set_config(1'b0, 1'b0, 1'b0, 1'b0, 10'd64, 10'd64, 10'd16);
    run_burst(10, 97, 1'b1, 1'b1);
    set_config(1'b1, 1'b1, 1'b1, 1'b1, 10'd8, 10'd200, 10'd32);
    run_burst(10, 6, 1'b1, 1'b1);

    // a few random settings
    for (int p = 0; p < 4; p++) begin
      set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 rand_size(), rand_size(), rand_size());
      run_burst(50, $urandom_range(30, 70), 1'(p), 1'(p >> 1));
    end

    // drain, let any trailing claim finish, then report
    wait_idle();
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/brq_pkg.sv
design/brq_ram.sv
design/brq_seq.sv
design/batched_ring_queue.sv
dv/tb.sv
